// File: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// Siren sweep tone sequencer package
// Command codes, activity codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Command codes carried in the op field
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_BEEP  = 2'd3;

  // Activity codes, also used as the internal mode
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_SIREN = 2'd1;
  localparam logic [1:0] MODE_BEEP  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIREN  = 3'd4;

  localparam int CFG_DATA_W = 16;
  localparam int FREQ_W     = 16;
  localparam int STEP_W     = 10;
  localparam int PERIOD_W   = 8;
  localparam int MAXS_W     = 10;
  localparam int ELAPSED_W  = 20;
  localparam int DUR_W      = 16;

  localparam logic [ELAPSED_W-1:0] MS_PER_S = 20'd1000;

  // Reset values of the registers
  localparam logic [FREQ_W-1:0]    RST_SWEEP_LOW  = 16'd400;
  localparam logic [FREQ_W-1:0]    RST_SWEEP_HIGH = 16'd1200;
  localparam logic [STEP_W-1:0]    RST_SWEEP_STEP = 10'd20;
  localparam logic [PERIOD_W-1:0]  RST_STEP_PER   = 8'd40;
  localparam logic [ELAPSED_W-1:0] RST_LIMIT_MS   = 20'd120000;

endpackage

// File: rtl/sst_in_if.sv
// ----------------------------------------------------------------------------
// Siren sweep tone sequencer command channel
// Valid/ready channel carrying one tick or command per transaction.
// ----------------------------------------------------------------------------
interface sst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] tone_hz;
  logic [15:0] beep_ms;

  modport source (output valid, output op, output tone_hz, output beep_ms, input ready);
  modport sink   (input valid, input op, input tone_hz, input beep_ms, output ready);
endinterface

// File: rtl/sst_out_if.sv
// ----------------------------------------------------------------------------
// Siren sweep tone sequencer result channel
// Valid/ready channel carrying the buzzer state after each command.
// ----------------------------------------------------------------------------
interface sst_out_if;
  logic        valid;
  logic        ready;
  logic        buzzer_on;
  logic [15:0] tone_freq;
  logic [1:0]  activity;
  logic        auto_stopped;

  modport source (output valid, output buzzer_on, output tone_freq, output activity,
                  output auto_stopped, input ready);
  modport sink   (input valid, input buzzer_on, input tone_freq, input activity,
                  input auto_stopped, output ready);
endinterface

// File: rtl/siren_sweep_tone_sequencer.sv
// ----------------------------------------------------------------------------
// Siren sweep tone sequencer
// Buzzer siren and beep sequencer advanced by one-millisecond tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   The cmd channel takes one transaction per item: a 1 ms tick, alarm start,
//   alarm stop or beep (with tone_hz and beep_ms). Every accepted item gives
//   exactly one transaction on the result channel, showing the buzzer state
//   after that item.
//   The result is in the output register on the cycle after acceptance.
//   Throughput is one item per cycle while the receiver takes each result;
//   the state update is a single pass of adders and comparators from the
//   sequencer state registers into the state and output registers.
//   cmd.ready is high while the output register is empty or being drained,
//   so a stalled receiver holds its result and the next item waits on it.
//   Reset (rst, synchronous) leaves the block idle with the buzzer off and
//   the registers at their defaults. The user must write the registers through
//   cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
//   The siren time limit is converted to milliseconds when it is written.
// ----------------------------------------------------------------------------
module siren_sweep_tone_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sst_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  sst_in_if.sink                             cmd,
  sst_out_if.source                          result
);

  // Configuration
  logic [sst_pkg::FREQ_W-1:0]    sweep_low_hz;
  logic [sst_pkg::FREQ_W-1:0]    sweep_high_hz;
  logic [sst_pkg::STEP_W-1:0]    sweep_step_hz;
  logic [sst_pkg::PERIOD_W-1:0]  step_period_ms;
  logic [sst_pkg::ELAPSED_W-1:0] limit_ms;

  // Sequencer state
  logic [1:0]                    mode, mode_next;
  logic [sst_pkg::FREQ_W-1:0]    sweep_freq, sweep_freq_next;
  logic                          sweeping_down, sweeping_down_next;
  logic [sst_pkg::PERIOD_W-1:0]  step_timer, step_timer_next;
  logic [sst_pkg::ELAPSED_W-1:0] siren_elapsed_ms, siren_elapsed_ms_next;
  logic [sst_pkg::DUR_W-1:0]     beep_remaining, beep_remaining_next;
  logic                          stop_pending, stop_pending_next;
  logic                          auto_stop;

  logic                          accept;
  logic [sst_pkg::PERIOD_W-1:0]  timer_inc;
  logic [sst_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic [sst_pkg::FREQ_W:0]      sum_up;
  logic [sst_pkg::FREQ_W:0]      low_plus_step;
  logic [sst_pkg::DUR_W-1:0]     remain_dec;
  logic                          over_limit;

  assign accept     = cmd.valid && cmd.ready;
  assign cmd.ready  = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_low_hz   <= sst_pkg::RST_SWEEP_LOW;
      sweep_high_hz  <= sst_pkg::RST_SWEEP_HIGH;
      sweep_step_hz  <= sst_pkg::RST_SWEEP_STEP;
      step_period_ms <= sst_pkg::RST_STEP_PER;
      limit_ms       <= sst_pkg::RST_LIMIT_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sst_pkg::REG_SWEEP_LOW:  sweep_low_hz   <= cfg_wdata;
        sst_pkg::REG_SWEEP_HIGH: sweep_high_hz  <= cfg_wdata;
        sst_pkg::REG_SWEEP_STEP: sweep_step_hz  <= cfg_wdata[sst_pkg::STEP_W-1:0];
        sst_pkg::REG_STEP_PER:   step_period_ms <= cfg_wdata[sst_pkg::PERIOD_W-1:0];
        sst_pkg::REG_MAX_SIREN:  limit_ms <= sst_pkg::ELAPSED_W'(cfg_wdata[sst_pkg::MAXS_W-1:0])
                                             * sst_pkg::MS_PER_S;
        default: ;
      endcase
    end
  end

  always_comb begin
    timer_inc     = step_timer + 8'd1;
    elapsed_inc   = (siren_elapsed_ms != '1) ? siren_elapsed_ms + 20'd1 : siren_elapsed_ms;
    sum_up        = {1'b0, sweep_freq} + 17'(sweep_step_hz);
    low_plus_step = {1'b0, sweep_low_hz} + 17'(sweep_step_hz);
    remain_dec    = (beep_remaining != '0) ? beep_remaining - 16'd1 : beep_remaining;
    over_limit    = elapsed_inc > limit_ms;

    mode_next             = mode;
    sweep_freq_next       = sweep_freq;
    sweeping_down_next    = sweeping_down;
    step_timer_next       = step_timer;
    siren_elapsed_ms_next = siren_elapsed_ms;
    beep_remaining_next   = beep_remaining;
    stop_pending_next     = stop_pending;
    auto_stop             = 1'b0;

    unique case (cmd.op)
      sst_pkg::OP_TICK: begin
        if (mode == sst_pkg::MODE_SIREN) begin
          siren_elapsed_ms_next = elapsed_inc;
          step_timer_next       = timer_inc;
          if (timer_inc >= step_period_ms) begin
            step_timer_next = '0;
            if (!sweeping_down) begin
              if (stop_pending || over_limit) begin
                mode_next         = sst_pkg::MODE_IDLE;
                sweep_freq_next   = '0;
                stop_pending_next = 1'b0;
                auto_stop         = over_limit;
              end else if (sum_up < {1'b0, sweep_high_hz}) begin
                sweep_freq_next = sum_up[sst_pkg::FREQ_W-1:0];
              end else if (sweep_high_hz > sweep_low_hz) begin
                sweeping_down_next = 1'b1;
                sweep_freq_next    = sweep_high_hz;
              end else begin
                sweep_freq_next = sweep_low_hz;
              end
            end else if ({1'b0, sweep_freq} > low_plus_step) begin
              sweep_freq_next = sweep_freq - 16'(sweep_step_hz);
            end else begin
              // Bottom of the downward sweep: start the next upward pass.
              sweeping_down_next = 1'b0;
              sweep_freq_next    = sweep_low_hz;
            end
          end
        end else if (mode == sst_pkg::MODE_BEEP) begin
          beep_remaining_next = remain_dec;
          if (remain_dec == '0) begin
            mode_next       = sst_pkg::MODE_IDLE;
            sweep_freq_next = '0;
          end
        end
      end
      sst_pkg::OP_START: begin
        if (mode == sst_pkg::MODE_IDLE) begin
          mode_next             = sst_pkg::MODE_SIREN;
          sweep_freq_next       = sweep_low_hz;
          sweeping_down_next    = 1'b0;
          step_timer_next       = '0;
          siren_elapsed_ms_next = '0;
          stop_pending_next     = 1'b0;
        end
      end
      sst_pkg::OP_STOP: begin
        if (mode == sst_pkg::MODE_SIREN) stop_pending_next = 1'b1;
      end
      sst_pkg::OP_BEEP: begin
        if (mode == sst_pkg::MODE_IDLE && cmd.beep_ms != '0) begin
          mode_next           = sst_pkg::MODE_BEEP;
          sweep_freq_next     = cmd.tone_hz;
          beep_remaining_next = cmd.beep_ms;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= sst_pkg::MODE_IDLE;
      sweep_freq       <= '0;
      sweeping_down    <= 1'b0;
      step_timer       <= '0;
      siren_elapsed_ms <= '0;
      beep_remaining   <= '0;
      stop_pending     <= 1'b0;
    end else if (accept) begin
      mode             <= mode_next;
      sweep_freq       <= sweep_freq_next;
      sweeping_down    <= sweeping_down_next;
      step_timer       <= step_timer_next;
      siren_elapsed_ms <= siren_elapsed_ms_next;
      beep_remaining   <= beep_remaining_next;
      stop_pending     <= stop_pending_next;
    end
  end

  // Output register: loaded with the state left by each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.buzzer_on    <= (mode_next == sst_pkg::MODE_SIREN) ||
                             (mode_next == sst_pkg::MODE_BEEP && sweep_freq_next != '0);
      result.tone_freq    <= ((mode_next == sst_pkg::MODE_SIREN) ||
                              (mode_next == sst_pkg::MODE_BEEP)) ? sweep_freq_next : '0;
      result.activity     <= mode_next;
      result.auto_stopped <= auto_stop;
    end
  end

  // A time-limit stop always leaves the block idle.
  a_auto_stop_idle: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.auto_stopped |-> result.activity == sst_pkg::MODE_IDLE)
    else $error("auto stop reported while not idle");

  // A silent buzzer reports no frequency.
  a_off_no_freq: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.buzzer_on |-> result.tone_freq == '0)
    else $error("frequency shown while buzzer off");

  // A beep in progress always has time left to run.
  a_beep_time_left: assert property (@(posedge clk) disable iff (rst)
    mode == sst_pkg::MODE_BEEP |-> beep_remaining != '0)
    else $error("beep mode with no time remaining");

  // Leaving the siren clears any pending stop.
  a_stop_cleared: assert property (@(posedge clk) disable iff (rst)
    $past(mode) == sst_pkg::MODE_SIREN && mode == sst_pkg::MODE_IDLE |-> !stop_pending)
    else $error("stop still pending after siren ended");

endmodule
